// ===== rtl/width_masked_integer_alu_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the width-masked integer ALU
// Each macro gives a clocked concurrent check, or nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef WIDTH_MASKED_INTEGER_ALU_DEFINES_SVH
`define WIDTH_MASKED_INTEGER_ALU_DEFINES_SVH
`ifndef SYNTH
// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("assertion failed");
// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, prop)
`define ASSERT_NEVER(lbl, expr)
`endif
`endif

// ===== rtl/wmia_pkg.sv =====
// ----------------------------------------------------------------------------
// Width-masked integer ALU package
// Opcodes, default width and the side payload that rides the divider.
// ----------------------------------------------------------------------------
package wmia_pkg;

	// Default operand width of the datapath.
	localparam int DEF_MAX_WIDTH = 32;

	// Operation codes.
	typedef enum logic [5:0] {
		OP_AND    = 6'd0,
		OP_OR     = 6'd1,
		OP_XOR    = 6'd2,
		OP_NAND   = 6'd3,
		OP_NOR    = 6'd4,
		OP_NOT    = 6'd5,
		OP_ANDR   = 6'd6,
		OP_ORR    = 6'd7,
		OP_XORR   = 6'd8,
		OP_ADD    = 6'd9,
		OP_SUB    = 6'd10,
		OP_INC    = 6'd11,
		OP_DEC    = 6'd12,
		OP_NEG    = 6'd13,
		OP_ABS    = 6'd14,
		OP_SMUL   = 6'd15,
		OP_UMUL   = 6'd16,
		OP_UDIV   = 6'd17,
		OP_UMOD   = 6'd18,
		OP_SDIV   = 6'd19,
		OP_SMOD   = 6'd20,
		OP_EQ     = 6'd21,
		OP_ULT    = 6'd22,
		OP_ULE    = 6'd23,
		OP_UGT    = 6'd24,
		OP_UGE    = 6'd25,
		OP_SLT    = 6'd26,
		OP_SLE    = 6'd27,
		OP_SGT    = 6'd28,
		OP_SGE    = 6'd29,
		OP_SLL    = 6'd30,
		OP_SRL    = 6'd31,
		OP_SRA    = 6'd32,
		OP_OHLSB  = 6'd33,
		OP_OHMSB  = 6'd34,
		OP_REV    = 6'd35,
		OP_SLICE  = 6'd36,
		OP_UMIN   = 6'd37,
		OP_UMAX   = 6'd38
	} op_t;

	// Everything an item carries past the divider besides its division operands.
	typedef struct packed {
		op_t         op;
		logic [5:0]  w;
		logic        an;
		logic        bn;
		logic        bz;
		logic        flag;
		logic [63:0] res;
	} side_t;

endpackage

// ===== rtl/width_masked_integer_alu.sv =====
// An accepted input beat passes through stage 1, stage 2, the divider stages and the output register.
// Throughput: one beat per cycle while the output is not stalled; the divider gives one quotient bit per stage,
// which sets the depth, and the full multiply shares stage 2 with the simple operations.
// A stall at the output backs up stage by stage; empty stages keep filling.
// Reset clears all valid bits asynchronously; payload registers are not reset.
// ----------------------------------------------------------------------------
// Width-masked integer ALU
// Logic, arithmetic, multiply, divide, compare, shift and bit operations on
// operands of a run-time width, masked to that width.
// ----------------------------------------------------------------------------
`include "width_masked_integer_alu_defines.svh"

module width_masked_integer_alu #(
	parameter int MAX_WIDTH = wmia_pkg::DEF_MAX_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// req_type[5:0], operand_a[37:6], operand_b[69:38], operand_width[75:70],
	// bit_position[81:76], update_width[87:82]
	input  logic [87:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// result[63:0], flag[64], zero padding[71:65]
	output logic [71:0] m_tdata
);

	localparam int W = MAX_WIDTH;
	localparam logic [5:0] WMAX = 6'(MAX_WIDTH);
	localparam logic [W-1:0] ONES = {W{1'b1}};

	// Mask of the low n bits of a W-bit word.
	function automatic logic [W-1:0] lmask(input logic [6:0] n);
		logic [W-1:0] r;
		r = (n >= 7'(W)) ? ONES : ~(ONES << n);
		return r;
	endfunction

	// Full-width bit reversal.
	function automatic logic [W-1:0] brev(input logic [W-1:0] x);
		logic [W-1:0] r;
		for (int i = 0; i < W; i++) begin
			r[i] = x[W-1-i];
		end
		return r;
	endfunction

	logic rdy_s1, rdy_s2, rdy_out, div_in_ready, div_out_valid;

	// ---------------- Stage 1: decode, clamp, mask ----------------
	wmia_pkg::op_t op_in;
	logic [5:0]    w_raw, w_in, uw_raw, uw_in;
	logic [W-1:0]  m_in, sb_in, a_in, b_in, na_in, nb_in;
	logic          an_in, bn_in, sdv_in, smul_in;

	assign op_in  = wmia_pkg::op_t'(s_tdata[5:0]);
	assign w_raw  = s_tdata[75:70];
	assign uw_raw = s_tdata[87:82];

	always_comb begin
		w_in    = (w_raw == 6'd0) ? 6'd1 : ((w_raw > WMAX) ? WMAX : w_raw);
		uw_in   = (uw_raw > WMAX) ? WMAX : uw_raw;
		m_in    = ONES >> (WMAX - w_in);
		sb_in   = m_in ^ (m_in >> 1);
		a_in    = s_tdata[6 +: W] & m_in;
		b_in    = s_tdata[38 +: W] & m_in;
		an_in   = |(a_in & sb_in);
		bn_in   = |(b_in & sb_in);
		na_in   = (~a_in + 1'b1) & m_in;
		nb_in   = (~b_in + 1'b1) & m_in;
		sdv_in  = (op_in == wmia_pkg::OP_SDIV) || (op_in == wmia_pkg::OP_SMOD);
		smul_in = (op_in == wmia_pkg::OP_SMUL);
	end

	logic          v_s1;
	wmia_pkg::op_t op_s1;
	logic [5:0]    w_s1, pos_s1, s_s1, uw_s1;
	logic [W-1:0]  m_s1, sb_s1, a_s1, b_s1, braw_s1, na_s1, ma_s1, mb_s1;
	logic          an_s1, bn_s1;
	logic [32:0]   ax_s1, bx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_tvalid) begin
			op_s1   <= op_in;
			w_s1    <= w_in;
			pos_s1  <= s_tdata[81:76];
			s_s1    <= (s_tdata[81:76] < w_in) ? s_tdata[81:76] : w_in;
			uw_s1   <= uw_in;
			m_s1    <= m_in;
			sb_s1   <= sb_in;
			a_s1    <= a_in;
			b_s1    <= b_in;
			braw_s1 <= s_tdata[38 +: W];
			na_s1   <= na_in;
			an_s1   <= an_in;
			bn_s1   <= bn_in;
			ma_s1   <= (sdv_in && an_in) ? na_in : a_in;
			mb_s1   <= (sdv_in && bn_in) ? nb_in : b_in;
			ax_s1   <= 33'(a_in) | ((smul_in && an_in) ? ~33'(m_in) : 33'd0);
			bx_s1   <= 33'(b_in) | ((smul_in && bn_in) ? ~33'(m_in) : 33'd0);
		end
	end

	// ---------------- Stage 2: simple operations and multiply ----------------
	logic [63:0]  r_c;
	logic         f_c;
	logic [W-1:0] sa_c, sbv_c, ra_c, rev_c;
	logic [6:0]   sl_c, top_c;
	logic [65:0]  prod_c;

	assign prod_c = 66'($signed(ax_s1) * $signed(bx_s1));

	always_comb begin
		sa_c  = a_s1 ^ sb_s1;
		sbv_c = b_s1 ^ sb_s1;
		ra_c  = brev(a_s1);
		rev_c = ra_c >> (WMAX - w_s1);
		sl_c  = ((7'(uw_s1) < (7'(w_s1) - 7'(pos_s1)))) ? 7'(uw_s1) : (7'(w_s1) - 7'(pos_s1));
		top_c = ((7'(pos_s1) + 7'(uw_s1)) < 7'(w_s1)) ? (7'(pos_s1) + 7'(uw_s1)) : 7'(w_s1);
		r_c   = '0;
		f_c   = 1'b0;
		case (op_s1)
			wmia_pkg::OP_AND:   r_c = 64'(a_s1 & b_s1);
			wmia_pkg::OP_OR:    r_c = 64'(a_s1 | b_s1);
			wmia_pkg::OP_XOR:   r_c = 64'(a_s1 ^ b_s1);
			wmia_pkg::OP_NAND:  r_c = 64'(~(a_s1 & b_s1) & m_s1);
			wmia_pkg::OP_NOR:   r_c = 64'(~(a_s1 | b_s1) & m_s1);
			wmia_pkg::OP_NOT:   r_c = 64'(~a_s1 & m_s1);
			wmia_pkg::OP_ANDR:  f_c = (a_s1 == m_s1);
			wmia_pkg::OP_ORR:   f_c = (a_s1 != '0);
			wmia_pkg::OP_XORR:  f_c = ^a_s1;
			wmia_pkg::OP_ADD:   r_c = 64'((a_s1 + b_s1) & m_s1);
			wmia_pkg::OP_SUB:   r_c = 64'((a_s1 - b_s1) & m_s1);
			wmia_pkg::OP_INC:   r_c = 64'((a_s1 + 1'b1) & m_s1);
			wmia_pkg::OP_DEC:   r_c = 64'((a_s1 - 1'b1) & m_s1);
			wmia_pkg::OP_NEG:   r_c = 64'(na_s1);
			wmia_pkg::OP_ABS:   r_c = 64'(an_s1 ? na_s1 : a_s1);
			wmia_pkg::OP_SMUL,
			wmia_pkg::OP_UMUL:  r_c = prod_c[63:0];
			wmia_pkg::OP_EQ:    f_c = (a_s1 == b_s1);
			wmia_pkg::OP_ULT:   f_c = (a_s1 < b_s1);
			wmia_pkg::OP_ULE:   f_c = (a_s1 <= b_s1);
			wmia_pkg::OP_UGT:   f_c = (a_s1 > b_s1);
			wmia_pkg::OP_UGE:   f_c = (a_s1 >= b_s1);
			wmia_pkg::OP_SLT:   f_c = (sa_c < sbv_c);
			wmia_pkg::OP_SLE:   f_c = (sa_c <= sbv_c);
			wmia_pkg::OP_SGT:   f_c = (sa_c > sbv_c);
			wmia_pkg::OP_SGE:   f_c = (sa_c >= sbv_c);
			wmia_pkg::OP_SLL:   r_c = (s_s1 >= w_s1) ? 64'd0 : 64'((a_s1 << s_s1) & m_s1);
			wmia_pkg::OP_SRL:   r_c = 64'(a_s1 >> s_s1);
			wmia_pkg::OP_SRA:
				r_c = 64'((a_s1 >> s_s1) | (an_s1 ? (m_s1 & ~(m_s1 >> s_s1)) : '0));
			wmia_pkg::OP_OHLSB:
				r_c = (a_s1 == '0) ? (64'd1 << w_s1) : 64'(a_s1 & (~a_s1 + 1'b1));
			wmia_pkg::OP_OHMSB:
				r_c = (a_s1 == '0) ? (64'd1 << w_s1) : 64'(brev(ra_c & (~ra_c + 1'b1)));
			wmia_pkg::OP_REV:   r_c = 64'(rev_c);
			wmia_pkg::OP_SLICE: begin
				if (pos_s1 >= w_s1) begin
					r_c = 64'(a_s1);
				end else begin
					r_c = 64'((a_s1 & lmask(7'(pos_s1)))
						| ((braw_s1 & lmask(sl_c)) << pos_s1)
						| (a_s1 & m_s1 & ~lmask(top_c)));
				end
			end
			wmia_pkg::OP_UMIN:  r_c = 64'((a_s1 < b_s1) ? a_s1 : b_s1);
			wmia_pkg::OP_UMAX:  r_c = 64'((a_s1 < b_s1) ? b_s1 : a_s1);
			default:            r_c = '0;
		endcase
		if (f_c) begin
			r_c = 64'd1;
		end
	end

	logic            v_s2;
	logic [W-1:0]    ma_s2, mb_s2;
	wmia_pkg::side_t sd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			ma_s2      <= ma_s1;
			mb_s2      <= mb_s1;
			sd_s2.op   <= op_s1;
			sd_s2.w    <= w_s1;
			sd_s2.an   <= an_s1;
			sd_s2.bn   <= bn_s1;
			sd_s2.bz   <= (b_s1 == '0);
			sd_s2.flag <= f_c;
			sd_s2.res  <= r_c;
		end
	end

	// ---------------- Divider stages ----------------
	logic [W-1:0]    q_d, r_d;
	wmia_pkg::side_t sd_d;

	wmia_div #(.W(W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (div_in_ready),
		.dividend  (ma_s2),
		.divisor   (mb_s2),
		.side_in   (sd_s2),
		.out_valid (div_out_valid),
		.out_ready (rdy_out),
		.quotient  (q_d),
		.remainder (r_d),
		.side_out  (sd_d)
	);

	// ---------------- Final stage: sign fix-up and selection ----------------
	logic [W-1:0] m_f, sb_f, nq_f, nr_f;
	logic [63:0]  pm_f, res_f;

	always_comb begin
		m_f  = ONES >> (WMAX - sd_d.w);
		sb_f = m_f ^ (m_f >> 1);
		nq_f = (~q_d + 1'b1) & m_f;
		nr_f = (~r_d + 1'b1) & m_f;
		pm_f = 64'hFFFF_FFFF_FFFF_FFFF >> (7'd64 - {sd_d.w, 1'b0});
		case (sd_d.op)
			wmia_pkg::OP_SMUL,
			wmia_pkg::OP_UMUL: res_f = sd_d.res & pm_f;
			wmia_pkg::OP_UDIV: res_f = 64'(sd_d.bz ? m_f : q_d);
			wmia_pkg::OP_UMOD: res_f = 64'(sd_d.bz ? '0 : r_d);
			wmia_pkg::OP_SDIV: begin
				if (sd_d.bz) begin
					res_f = 64'(sd_d.an ? sb_f : (m_f >> 1));
				end else begin
					res_f = 64'((sd_d.an != sd_d.bn) ? nq_f : q_d);
				end
			end
			wmia_pkg::OP_SMOD: res_f = 64'(sd_d.bz ? '0 : (sd_d.an ? nr_f : r_d));
			default:           res_f = sd_d.res;
		endcase
	end

	logic        v_out;
	logic [63:0] res_out;
	logic        flag_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (rdy_out) begin
			v_out <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && div_out_valid) begin
			res_out  <= res_f;
			flag_out <= sd_d.flag;
		end
	end

	// Ready chain: each stage loads when empty or when its beat moves on.
	assign rdy_out  = !v_out || m_tready;
	assign rdy_s2   = !v_s2 || div_in_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	assign m_tvalid = v_out;
	assign m_tdata  = {7'd0, flag_out, res_out};

	// ---------------- Checks ----------------
	// An empty output register frees the whole chain for a new beat.
	`ASSERT_PROP(a_ready_when_out_empty, !m_tvalid |-> s_tready)
	// A set flag always comes with a result of exactly one.
	`ASSERT_NEVER(a_flag_result, m_tvalid && m_tdata[64] && (m_tdata[63:0] != 64'd1))
	// A beat in stage 2 held back by the divider stays put.
	`ASSERT_PROP(a_s2_holds, v_s2 && !div_in_ready |=> v_s2 && $stable(sd_s2))

endmodule

// ===== rtl/wmia_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, W stages, with a side payload carried alongside.
// ----------------------------------------------------------------------------
module wmia_div #(
	parameter int W = wmia_pkg::DEF_MAX_WIDTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [W-1:0]    dividend,
	input  logic [W-1:0]    divisor,
	input  wmia_pkg::side_t side_in,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [W-1:0]    quotient,
	output logic [W-1:0]    remainder,
	output wmia_pkg::side_t side_out
);

	logic [W-1:0]    v_q;
	logic [W-1:0]    rdy;
	logic [W-1:0]    rem_q  [W];
	logic [W-1:0]    qd_q   [W];
	logic [W-1:0]    dv_q   [W];
	wmia_pkg::side_t side_q [W];

	// Stage ready: a stage may load when empty or when its beat moves on.
	always_comb begin
		rdy[W-1] = !v_q[W-1] || out_ready;
		for (int i = W - 2; i >= 0; i--) begin
			rdy[i] = !v_q[i] || rdy[i+1];
		end
	end

	assign in_ready = rdy[0];

	// Each stage shifts in one dividend bit and subtracts the divisor when it fits.
	for (genvar i = 0; i < W; i++) begin : g_stage
		logic [W-1:0]    rem_in;
		logic [W-1:0]    qd_in;
		logic [W-1:0]    dv_in;
		wmia_pkg::side_t sd_in;
		logic            v_in;
		logic [W:0]      trial;
		logic [W:0]      diff;
		logic            fits;

		if (i == 0) begin : g_first
			assign rem_in = '0;
			assign qd_in  = dividend;
			assign dv_in  = divisor;
			assign sd_in  = side_in;
			assign v_in   = in_valid;
		end else begin : g_next
			assign rem_in = rem_q[i-1];
			assign qd_in  = qd_q[i-1];
			assign dv_in  = dv_q[i-1];
			assign sd_in  = side_q[i-1];
			assign v_in   = v_q[i-1];
		end

		assign trial = {rem_in, qd_in[W-1]};
		assign diff  = trial - {1'b0, dv_in};
		assign fits  = trial >= {1'b0, dv_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i] <= 1'b0;
			end else if (rdy[i]) begin
				v_q[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[i] && v_in) begin
				rem_q[i]  <= fits ? diff[W-1:0] : trial[W-1:0];
				qd_q[i]   <= {qd_in[W-2:0], fits};
				dv_q[i]   <= dv_in;
				side_q[i] <= sd_in;
			end
		end
	end

	assign out_valid = v_q[W-1];
	assign quotient  = qd_q[W-1];
	assign remainder = rem_q[W-1];
	assign side_out  = side_q[W-1];

endmodule

// ===== bench/alu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ALU result checker
// Watches both stream channels of the ALU, computes the expected result of
// each accepted request beat and compares it with the result beats in order.
// ----------------------------------------------------------------------------
module alu_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [87:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,
	output int          errors,
	output int          pending
);

	logic [64:0] expected_q[$];

	function automatic logic [63:0] low_ones(input int n);
		return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
	endfunction

	// Expected {flag, result} for one request beat.
	function automatic logic [64:0] alu_predict(input logic [87:0] d);
		logic [5:0] op;
		int w, pos, uw, s, sl, top, i;
		logic [63:0] m, sb, a, b, r, ma, mb, q, xa, xb;
		logic an, bn, fl, has_fl;
		op = d[5:0];
		w = d[75:70]; pos = d[81:76]; uw = d[87:82];
		if (w < 1) w = 1;
		if (w > 32) w = 32;
		if (uw > 32) uw = 32;
		m = low_ones(w);
		sb = 64'd1 << (w - 1);
		a = {32'd0, d[37:6]} & m;
		b = {32'd0, d[69:38]} & m;
		s = (pos < w) ? pos : w;
		an = (a & sb) != 0; bn = (b & sb) != 0;
		r = 0; fl = 0; has_fl = 0;
		case (op)
			wmia_pkg::OP_AND:  r = a & b;
			wmia_pkg::OP_OR:   r = a | b;
			wmia_pkg::OP_XOR:  r = a ^ b;
			wmia_pkg::OP_NAND: r = ~(a & b) & m;
			wmia_pkg::OP_NOR:  r = ~(a | b) & m;
			wmia_pkg::OP_NOT:  r = ~a & m;
			wmia_pkg::OP_ANDR: begin has_fl = 1; fl = (a == m); end
			wmia_pkg::OP_ORR:  begin has_fl = 1; fl = (a != 0); end
			wmia_pkg::OP_XORR: begin has_fl = 1; fl = ^a; end
			wmia_pkg::OP_ADD:  r = (a + b) & m;
			wmia_pkg::OP_SUB:  r = (a - b) & m;
			wmia_pkg::OP_INC:  r = (a + 1) & m;
			wmia_pkg::OP_DEC:  r = (a - 1) & m;
			wmia_pkg::OP_NEG:  r = (0 - a) & m;
			wmia_pkg::OP_ABS:  r = an ? ((0 - a) & m) : a;
			wmia_pkg::OP_SMUL: begin
				xa = an ? (a | ~m) : a;
				xb = bn ? (b | ~m) : b;
				r = (xa * xb) & low_ones(2 * w);
			end
			wmia_pkg::OP_UMUL: r = a * b;
			wmia_pkg::OP_UDIV: r = (b != 0) ? a / b : m;
			wmia_pkg::OP_UMOD: r = (b != 0) ? a % b : 0;
			wmia_pkg::OP_SDIV, wmia_pkg::OP_SMOD: begin
				ma = an ? ((0 - a) & m) : a;
				mb = bn ? ((0 - b) & m) : b;
				if (op == wmia_pkg::OP_SDIV) begin
					if (b == 0) r = an ? sb : (m >> 1);
					else begin
						q = ma / mb;
						r = ((an != bn) ? (0 - q) : q) & m;
					end
				end else if (b != 0) begin
					q = ma % mb;
					r = (an ? (0 - q) : q) & m;
				end
			end
			wmia_pkg::OP_EQ:  begin has_fl = 1; fl = a == b; end
			wmia_pkg::OP_ULT: begin has_fl = 1; fl = a < b; end
			wmia_pkg::OP_ULE: begin has_fl = 1; fl = a <= b; end
			wmia_pkg::OP_UGT: begin has_fl = 1; fl = a > b; end
			wmia_pkg::OP_UGE: begin has_fl = 1; fl = a >= b; end
			wmia_pkg::OP_SLT: begin has_fl = 1; fl = (a ^ sb) < (b ^ sb); end
			wmia_pkg::OP_SLE: begin has_fl = 1; fl = (a ^ sb) <= (b ^ sb); end
			wmia_pkg::OP_SGT: begin has_fl = 1; fl = (a ^ sb) > (b ^ sb); end
			wmia_pkg::OP_SGE: begin has_fl = 1; fl = (a ^ sb) >= (b ^ sb); end
			wmia_pkg::OP_SLL: r = (s >= w) ? 0 : ((a << s) & m);
			wmia_pkg::OP_SRL: r = a >> s;
			wmia_pkg::OP_SRA: begin
				r = a >> s;
				if (an) r |= m & ~(m >> s);
			end
			wmia_pkg::OP_OHLSB: r = (a != 0) ? (a & (0 - a)) : (64'd1 << w);
			wmia_pkg::OP_OHMSB: begin
				if (a == 0) r = 64'd1 << w;
				else for (i = 0; i < w; i++) if (a[i]) r = 64'd1 << i;
			end
			wmia_pkg::OP_REV: for (i = 0; i < w; i++) if (a[i]) r |= 64'd1 << (w - 1 - i);
			wmia_pkg::OP_SLICE: begin
				if (pos >= w) r = a;
				else begin
					sl = (uw < (w - pos)) ? uw : (w - pos);
					top = ((pos + uw) < w) ? (pos + uw) : w;
					r = (a & low_ones(pos))
						| (({32'd0, d[69:38]} & low_ones(sl)) << pos)
						| (a & m & ~low_ones(top));
				end
			end
			wmia_pkg::OP_UMIN: r = (a < b) ? a : b;
			wmia_pkg::OP_UMAX: r = (a < b) ? b : a;
			default: r = 0;
		endcase
		if (has_fl) return {fl, 63'd0, fl};
		return {1'b0, r};
	endfunction

	// Prints one mismatch line and counts it.
	task automatic report_mismatch(input string what, input logic [64:0] got,
		input logic [64:0] want);
		errors++;
		$display("MISMATCH %s: got %h expected %h", what, got, want);
	endtask

	initial errors = 0;
	assign pending = expected_q.size();

	// Requests go in on the slave side, results are checked on the master side.
	always @(posedge clk) begin
		logic [64:0] want;
		if (arst_n) begin
			if (s_tvalid && s_tready) expected_q = {expected_q, alu_predict(s_tdata)};
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0)
					report_mismatch("unexpected beat", m_tdata[64:0], '0);
				else begin
					want = expected_q.pop_front();
					if (m_tdata[63:0] !== want[63:0])
						report_mismatch("result", m_tdata[64:0], want);
					if (m_tdata[64] !== want[64])
						report_mismatch("flag", m_tdata[64:0], want);
				end
			end
		end
	end
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Width-masked integer ALU testbench
// Drives directed and random request beats with random gaps and output
// stalls; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [87:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	int          errors;
	int          pending;
	bit          calm;

	width_masked_integer_alu dut (.*);

	alu_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Receiver stalls with a probability of about 29 in a hundred, except in calm stretches.
	always @(posedge clk)
		m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 29);

	// Sends one request beat, with an optional random gap before it.
	task automatic send_req(input logic [5:0] op, input logic [31:0] a,
		input logic [31:0] b, input logic [5:0] w, input logic [5:0] pos,
		input logic [5:0] uw);
		while (!calm && $urandom_range(99) < 29) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {uw, pos, w, b, a, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_operand(input int kind);
		case (kind)
			0: return 32'd0;
			1: return '1;
			2: return 32'h8000_0000 >> $urandom_range(31);
			3: return $urandom_range(7);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int n, w;
		logic [5:0] op;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		calm = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: every opcode at the extreme widths and operand corners.
		for (n = 0; n < 39; n++) begin
			send_req(6'(n), 32'hFFFF_FFFF, 32'h0, 6'd32, 6'd63, 6'd63);
			send_req(6'(n), 32'h8000_0000, 32'hFFFF_FFFF, 6'd0, 6'd0, 6'd0);
		end
		send_req(wmia_pkg::OP_SDIV, 32'h8000_0000, 32'hFFFF_FFFF, 6'd32, 6'd0, 6'd0);
		send_req(wmia_pkg::OP_SDIV, 32'h8000_0000, 32'h0, 6'd32, 6'd0, 6'd0);
		send_req(wmia_pkg::OP_SDIV, 32'h7, 32'h0, 6'd32, 6'd0, 6'd0);
		send_req(wmia_pkg::OP_ABS, 32'h80, 32'h0, 6'd8, 6'd0, 6'd0);
		send_req(wmia_pkg::OP_SRA, 32'h80, 32'h0, 6'd8, 6'd40, 6'd0);
		send_req(wmia_pkg::OP_OHMSB, 32'h0, 32'h0, 6'd63, 6'd0, 6'd0);
		send_req(wmia_pkg::OP_SLICE, 32'h0F0F, 32'hFFFF_FFFF, 6'd16, 6'd12, 6'd20);
		send_req(6'd63, '1, '1, 6'd32, 6'd0, 6'd0);

		// Hold off until every result is back.
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		// Random: mostly small widths, with a calm stretch in the middle.
		for (n = 0; n < 820; n++) begin
			calm = (n >= 400 && n < 520);
			op = ($urandom_range(19) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(38));
			case ($urandom_range(3))
				0: w = $urandom_range(63);
				1: w = 32;
				default: w = $urandom_range(1, 12);
			endcase
			send_req(op, rand_operand($urandom_range(6)), rand_operand($urandom_range(6)),
				6'(w), 6'($urandom_range(63)), 6'($urandom_range(63)));
		end
		s_tvalid <= 0;
		calm = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2ms;
		$display("Mismatches found");
		$finish;
	end
endmodule
